// ===== design/plb_pkg.sv =====
package plb_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;

  // request kinds
  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_READ      = 3'd6,
    KIND_UNUSED    = 3'd7
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // per-cycle action broadcast along the cell row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_READ   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== design/positional_list_buffer.sv =====
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Request channel: in_valid/in_stall with kind, position and value; a
// transaction inserts (front, back, 1-based position), deletes (front, back,
// position) or reads at a position. Result channel: out_valid/out_stall with
// status, element_count and read_value, exactly one result per request.
// out_valid rises in the cycle after acceptance. While in_stall is low, one
// request is taken per cycle: every cell shifts backward, forward or holds in the
// same cycle, and the read word travels along the row to the result register.
// Refused requests (bad position, full, empty) leave the list unchanged.
// While the result register holds a result that the receiver stalls, in_stall
// is raised and the held result stays unchanged; once it is taken a new
// request is accepted in the same cycle.
// Reset empties the list (element count zero) and clears out_valid; cell
// contents are not cleared and are never read before being written.
module positional_list_buffer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        kind,
  input  logic [plb_pkg::POS_W-1:0]         position,
  input  logic signed [plb_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [plb_pkg::POS_W-1:0]         element_count,
  output logic signed [plb_pkg::DATA_W-1:0] read_value
);
  import plb_pkg::*;

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] rd_chain  [CAPACITY+1];

  assign rd_chain[0] = '0;

  // sequencer: decode, count and result register
  plb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .element_count (element_count),
    .read_value    (read_value),
    .cmd           (cmd),
    .rd_data       (rd_chain[CAPACITY])
  );

  // row of storage cells, each wired to its two neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    plb_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .slot       (IDX_W'(i)),
      .left_data  (left_w),
      .right_data (right_w),
      .rd_in      (rd_chain[i]),
      .rd_out     (rd_chain[i+1]),
      .data       (cell_data[i])
    );
  end

endmodule

// ===== design/plb_cell.sv =====
module plb_cell (
  input  logic                              clk,
  input  plb_pkg::cell_cmd_t                cmd,
  input  logic [plb_pkg::IDX_W-1:0]         slot,
  input  logic signed [plb_pkg::DATA_W-1:0] left_data,
  input  logic signed [plb_pkg::DATA_W-1:0] right_data,
  input  logic signed [plb_pkg::DATA_W-1:0] rd_in,
  output logic signed [plb_pkg::DATA_W-1:0] rd_out,
  output logic signed [plb_pkg::DATA_W-1:0] data
);
  import plb_pkg::*;

  logic signed [DATA_W-1:0] data_next;

  // shift right on insert, shift left on delete, else hold
  always_comb begin
    data_next = data;
    case (cmd.op)
      CELL_INSERT: begin
        if (slot > cmd.idx) begin
          data_next = left_data;
        end else if (slot == cmd.idx) begin
          data_next = cmd.value;
        end
      end
      CELL_DELETE: begin
        if (slot >= cmd.idx) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // read bus passes through the row, the addressed cell merges its word
  assign rd_out = (cmd.op == CELL_READ && slot == cmd.idx) ? (rd_in | data) : rd_in;

endmodule

// ===== design/plb_ctrl.sv =====
module plb_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        kind,
  input  logic [plb_pkg::POS_W-1:0]         position,
  input  logic signed [plb_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [plb_pkg::POS_W-1:0]         element_count,
  output logic signed [plb_pkg::DATA_W-1:0] read_value,
  output plb_pkg::cell_cmd_t                cmd,
  input  logic signed [plb_pkg::DATA_W-1:0] rd_data
);
  import plb_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [POS_W-1:0] cnt_ext;
  logic             full;
  logic             empty;
  logic             accept;
  status_t          st;
  cell_op_t         op;
  logic [POS_W-1:0] tgt;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign cnt_ext  = POS_W'(count);
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  // decode request against the current element count
  always_comb begin
    st  = ST_OK;
    op  = CELL_HOLD;
    tgt = '0;
    case (kind_t'(kind))
      KIND_INS_FRONT: begin
        if (full) st = ST_FULL;
        else op = CELL_INSERT;
      end
      KIND_INS_BACK: begin
        tgt = cnt_ext;
        if (full) st = ST_FULL;
        else op = CELL_INSERT;
      end
      KIND_INS_POS: begin
        tgt = position - POS_W'(1);
        if (position == '0 || position > cnt_ext + POS_W'(1)) st = ST_BADPOS;
        else if (full) st = ST_FULL;
        else op = CELL_INSERT;
      end
      KIND_DEL_FRONT: begin
        if (empty) st = ST_EMPTY;
        else op = CELL_DELETE;
      end
      KIND_DEL_BACK: begin
        tgt = cnt_ext - POS_W'(1);
        if (empty) st = ST_EMPTY;
        else op = CELL_DELETE;
      end
      KIND_DEL_POS: begin
        tgt = position - POS_W'(1);
        if (empty) st = ST_EMPTY;
        else if (position == '0 || position > cnt_ext) st = ST_BADPOS;
        else op = CELL_DELETE;
      end
      KIND_READ: begin
        tgt = position - POS_W'(1);
        if (empty) st = ST_EMPTY;
        else if (position == '0 || position > cnt_ext) st = ST_BADPOS;
        else op = CELL_READ;
      end
      default: st = ST_BADPOS;
    endcase
  end

  // command to the cells only for an accepted transaction
  always_comb begin
    cmd.op    = accept ? op : CELL_HOLD;
    cmd.idx   = tgt[IDX_W-1:0];
    cmd.value = value;
  end

  always_comb begin
    case (cmd.op)
      CELL_INSERT: count_next = count + CNT_W'(1);
      CELL_DELETE: count_next = count - CNT_W'(1);
      default:     count_next = count;
    endcase
  end

  // element count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      status        <= st;
      element_count <= POS_W'(count_next);
      read_value    <= rd_data;
    end
  end

endmodule

// ===== tb/tb_positional_list_buffer.sv =====
module tb_positional_list_buffer;
  import plb_pkg::*;

  typedef struct {
    kind_t                    kind;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } request_t;

  typedef struct {
    status_t                  status;
    logic [POS_W-1:0]         count;
    logic signed [DATA_W-1:0] word;
  } reply_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               kind = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic [POS_W-1:0]         element_count;
  logic signed [DATA_W-1:0] read_value;

  // shadow copy of the list contents
  logic signed [DATA_W-1:0] shadow_list [CAPACITY];
  int                       shadow_len = 0;

  request_t pending_q [$];
  reply_t   reply_q [$];
  request_t cur_req;
  reply_t   want;
  int       accepted_n = 0;
  int       results_n = 0;
  int       total_n = 0;
  int       mismatches = 0;
  int       send_gap = 0;
  int       hold_left = 0;
  bit       req_taken = 1'b0;

  positional_list_buffer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .element_count (element_count),
    .read_value    (read_value)
  );

  initial forever #6 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // applies one request to the shadow list and returns the reply it should get
  function automatic reply_t list_reply(request_t req);
    reply_t r;
    int     slot;
    r.status = ST_OK;
    r.word   = '0;
    case (req.kind)
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
        if (req.kind == KIND_INS_FRONT) slot = 0;
        else if (req.kind == KIND_INS_BACK) slot = shadow_len;
        else slot = int'(req.pos) - 1;
        if (req.kind == KIND_INS_POS && (req.pos < 1 || req.pos > shadow_len + 1)) begin
          r.status = ST_BADPOS;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[slot] = req.value;
          shadow_len++;
        end
      end
      KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_POS: begin
        if (req.kind == KIND_DEL_FRONT) slot = 0;
        else if (req.kind == KIND_DEL_BACK) slot = shadow_len - 1;
        else slot = int'(req.pos) - 1;
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (req.kind == KIND_DEL_POS && (req.pos < 1 || req.pos > shadow_len)) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = slot; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      KIND_READ: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (req.pos < 1 || req.pos > shadow_len) r.status = ST_BADPOS;
        else r.word = shadow_list[int'(req.pos) - 1];
      end
      default: r.status = ST_BADPOS;
    endcase
    r.count = POS_W'(shadow_len);
    return r;
  endfunction

  task automatic queue_req(kind_t k, int p, logic signed [DATA_W-1:0] v);
    request_t r;
    r.kind  = k;
    r.pos   = POS_W'(p);
    r.value = v;
    pending_q.push_back(r);
  endtask

  // request driver, changes at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_req = pending_q.pop_front();
        in_valid <= 1'b1;
        kind     <= cur_req.kind;
        position <= cur_req.pos;
        value    <= cur_req.value;
        // quiet stretches with back-to-back transactions
        send_gap = ((accepted_n % 300) >= 200) ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // request acceptance and prediction
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      reply_q.push_back(list_reply('{kind_t'(kind), position, value}));
      req_taken = 1'b1;
      accepted_n++;
    end
  end

  // result receiver stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result status %0d count %0d read %0d",
                 $time, status, element_count, read_value);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
          mismatches++;
        end
        if (element_count !== want.count) begin
          $display("%0t: element_count expected %0d got %0d", $time, want.count,
                   element_count);
          mismatches++;
        end
        if (read_value !== want.word) begin
          $display("%0t: read_value expected %0d got %0d", $time, want.word, read_value);
          mismatches++;
        end
      end
      results_n++;
      hold_left = ((results_n % 250) < 60) ? 0 : $urandom_range(0, 4);
    end
  end

  // stimulus and end of run
  initial begin
    int    mood;
    int    ins_pct;
    int    roll;
    int    p;
    kind_t k;

    // empty list, bad insert, read and delete positions, an unused kind, extremes of value and position
    queue_req(KIND_READ, 1, 0);
    queue_req(KIND_DEL_FRONT, 0, 0);
    queue_req(KIND_DEL_BACK, 0, 0);
    queue_req(KIND_DEL_POS, 1, 0);
    queue_req(KIND_INS_POS, 0, 5);
    queue_req(KIND_INS_POS, 2, 6);
    queue_req(KIND_INS_POS, 1, 32'h7fffffff);
    queue_req(KIND_INS_FRONT, 0, 32'h80000000);
    queue_req(KIND_INS_BACK, 127, -1);
    queue_req(KIND_INS_POS, 4, 0);
    queue_req(KIND_INS_POS, 2, 32'h5a5aa5a5);
    queue_req(KIND_READ, 0, 0);
    queue_req(KIND_READ, 5, 0);
    queue_req(KIND_READ, 6, 0);
    queue_req(KIND_READ, 127, 0);
    queue_req(KIND_READ, 1, 0);
    queue_req(KIND_DEL_POS, 0, 0);
    queue_req(KIND_DEL_POS, 6, 0);
    queue_req(KIND_DEL_POS, 127, 0);
    queue_req(KIND_UNUSED, 3, 32'h12345678);
    queue_req(KIND_DEL_POS, 5, 0);
    queue_req(KIND_DEL_POS, 2, 0);
    queue_req(KIND_DEL_BACK, 0, 0);
    queue_req(KIND_DEL_FRONT, 0, 0);
    queue_req(KIND_READ, 1, 0);

    // random traffic in moods that fill, drain or churn the list
    for (int n = 0; n < 950; n++) begin
      if (n % 50 == 0) mood = $urandom_range(0, 2);
      ins_pct = (mood == 0) ? 75 : (mood == 1) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 3) k = KIND_UNUSED;
      else if (roll < 18) k = KIND_READ;
      else if ($urandom_range(0, 99) < ins_pct) k = kind_t'($urandom_range(0, 2));
      else k = kind_t'($urandom_range(3, 5));
      roll = $urandom_range(0, 99);
      if (roll < 5) p = 0;
      else if (roll < 90) p = $urandom_range(1, CAPACITY + 1);
      else p = $urandom_range(CAPACITY + 2, 127);
      queue_req(k, p, $urandom);
    end
    total_n = pending_q.size();

    while (accepted_n < total_n || reply_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
